// ===== hw/rtl/spibse_pkg.sv =====
package spibse_pkg;

    // Request codes carried by an input item.
    localparam logic [1:0] REQ_START    = 2'd0;
    localparam logic [1:0] REQ_EDGE     = 2'd1;
    localparam logic [1:0] REQ_DESELECT = 2'd2;

    // Operating modes held in the spi_mode register.
    localparam logic [1:0] MODE_OFF    = 2'd0;
    localparam logic [1:0] MODE_MASTER = 2'd1;
    localparam logic [1:0] MODE_SLAVE  = 2'd2;

    // Register indexes on the configuration port.
    localparam int unsigned CFG_ADDR_W = 3;
    localparam int unsigned CFG_DATA_W = 2;
    localparam logic [CFG_ADDR_W-1:0] CFG_SPI_MODE           = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_LSB_FIRST          = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_LEAD_EDGE_FALLING  = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] CFG_SAMPLE_ON_TRAILING = 3'd3;

    localparam int unsigned TX_BYTE_W = 8;
    localparam int unsigned RX_BYTE_W = 8;

    typedef struct packed {
        logic [1:0] spi_mode;
        logic       lsb_first;
        logic       lead_edge_falling;
        logic       sample_on_trailing;
    } cfg_t;

    typedef struct packed {
        logic [1:0]           req_type;
        logic [TX_BYTE_W-1:0] tx_byte;
        logic                 edge_rising;
        logic                 data_in;
    } item_t;

    typedef struct packed {
        logic                 data_out;
        logic                 sck_level;
        logic                 want_tick;
        logic                 byte_done;
        logic [RX_BYTE_W-1:0] rx_byte;
    } result_t;

endpackage

// ===== hw/rtl/spibse_core.sv =====
module spibse_core #(
    parameter int unsigned BYTE_BITS = 8
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  spibse_pkg::cfg_t    cfg,
    input  logic                abort,
    input  logic                step,
    input  spibse_pkg::item_t   item,
    output spibse_pkg::result_t result
);

    localparam int unsigned PW = (BYTE_BITS > 1) ? $clog2(BYTE_BITS) : 1;
    localparam int unsigned CW = $clog2(BYTE_BITS + 1);
    localparam logic [PW-1:0] LAST_BIT = PW'(BYTE_BITS - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(BYTE_BITS);

    logic [CW-1:0]        bit_pos_reg, bit_pos_next;
    logic [BYTE_BITS-1:0] tx_shift_reg, tx_shift_next;
    logic [BYTE_BITS-1:0] rx_shift_reg, rx_shift_next;
    logic                 clk_level_reg, clk_level_next;
    logic                 active_reg, active_next;
    logic                 out_level_reg, out_level_next;

    logic [BYTE_BITS-1:0] tx_load;
    logic [CW-1:0]        bit_pos_inc;
    logic [PW-1:0]        cur_idx, inc_idx;
    logic                 master, slave, rising, leading, done;

    // Transfer bit k maps to register bit k, or to the mirrored bit for MSB first.
    function automatic logic [PW-1:0] bit_index(input logic [CW-1:0] k, input logic lsb);
        logic [PW-1:0] kk;
        kk = k[PW-1:0];
        return lsb ? kk : (LAST_BIT - kk);
    endfunction

    genvar g;
    generate
        for (g = 0; g < BYTE_BITS; g++) begin : g_tx
            if (g < spibse_pkg::TX_BYTE_W) begin : g_in
                assign tx_load[g] = item.tx_byte[g];
            end else begin : g_pad
                assign tx_load[g] = 1'b0;
            end
        end
    endgenerate

    assign master      = (cfg.spi_mode == spibse_pkg::MODE_MASTER);
    assign slave       = (cfg.spi_mode == spibse_pkg::MODE_SLAVE);
    assign bit_pos_inc = bit_pos_reg + CW'(1);
    assign cur_idx     = bit_index(bit_pos_reg, cfg.lsb_first);
    assign inc_idx     = bit_index(bit_pos_inc, cfg.lsb_first);
    assign rising      = master ? ~clk_level_reg : item.edge_rising;
    assign leading     = (rising != cfg.lead_edge_falling);

    always_comb begin
        bit_pos_next   = bit_pos_reg;
        tx_shift_next  = tx_shift_reg;
        rx_shift_next  = rx_shift_reg;
        clk_level_next = clk_level_reg;
        active_next    = active_reg;
        out_level_next = out_level_reg;
        done           = 1'b0;

        if (step && (master || slave)) begin
            case (item.req_type)
                spibse_pkg::REQ_START: begin
                    tx_shift_next = tx_load;
                    rx_shift_next = '0;
                    bit_pos_next  = '0;
                    active_next   = 1'b1;
                    if (master) begin
                        clk_level_next = cfg.lead_edge_falling;
                    end
                    if (!cfg.sample_on_trailing) begin
                        out_level_next = tx_load[bit_index('0, cfg.lsb_first)];
                    end
                end
                spibse_pkg::REQ_EDGE: begin
                    if (active_reg) begin
                        if (master) begin
                            clk_level_next = ~clk_level_reg;
                        end
                        if (leading) begin
                            if (cfg.sample_on_trailing) begin
                                out_level_next = tx_shift_reg[cur_idx];
                            end else if (item.data_in) begin
                                rx_shift_next[cur_idx] = 1'b1;
                            end
                        end else begin
                            if (cfg.sample_on_trailing && item.data_in) begin
                                rx_shift_next[cur_idx] = 1'b1;
                            end
                            if (bit_pos_inc >= FULL_CNT) begin
                                bit_pos_next   = FULL_CNT;
                                active_next    = 1'b0;
                                out_level_next = 1'b1;
                                done           = 1'b1;
                            end else begin
                                bit_pos_next = bit_pos_inc;
                                if (!cfg.sample_on_trailing) begin
                                    out_level_next = tx_shift_reg[inc_idx];
                                end
                            end
                        end
                    end
                end
                spibse_pkg::REQ_DESELECT: begin
                    if (slave) begin
                        active_next    = 1'b0;
                        out_level_next = 1'b1;
                    end
                end
                default: begin
                end
            endcase
        end

        // A change of mode drops any transfer and parks the line high.
        if (abort) begin
            active_next    = 1'b0;
            out_level_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bit_pos_reg   <= '0;
            tx_shift_reg  <= '0;
            rx_shift_reg  <= '0;
            clk_level_reg <= 1'b0;
            active_reg    <= 1'b0;
            out_level_reg <= 1'b1;
        end else begin
            bit_pos_reg   <= bit_pos_next;
            tx_shift_reg  <= tx_shift_next;
            rx_shift_reg  <= rx_shift_next;
            clk_level_reg <= clk_level_next;
            active_reg    <= active_next;
            out_level_reg <= out_level_next;
        end
    end

    generate
        for (g = 0; g < spibse_pkg::RX_BYTE_W; g++) begin : g_rx
            if (g < BYTE_BITS) begin : g_in
                assign result.rx_byte[g] = rx_shift_next[g];
            end else begin : g_pad
                assign result.rx_byte[g] = 1'b0;
            end
        end
    endgenerate

    assign result.data_out  = out_level_next;
    assign result.sck_level = master & clk_level_next;
    assign result.want_tick = master & active_next;
    assign result.byte_done = done;

endmodule

// ===== hw/rtl/spi_byte_shift_engine_unit.sv =====
// SPI shift engine for one word of BYTE_BITS bits, master or slave.
//
// Input channel (s_valid / s_ready): each item is a start, a clock edge or
// tick, or a slave deselect, with the transmit byte, the slave edge direction
// and the sampled receive data level. Every accepted item yields exactly one
// result item on the output channel (m_valid / m_ready): the transmit line
// level, the master clock level, a request for another tick, a done flag
// and the receive byte assembled so far.
//
// Timing: an item is captured in an input register, its state update runs in
// combinational logic, and the result lands in an output register. One item
// per cycle is sustained while the receiver does not stall.
//
// When the receiver stalls, the output register holds its result and the
// input register holds one more item; only when both are full does s_ready
// fall. Reset (aresetn, synchronous, active low) empties both registers, clears
// configuration and engine state, and parks the data line high. Configuration
// is written by the user through cfg_we / cfg_addr / cfg_wdata while the block
// is idle, not enforced here. A spi_mode change aborts any transfer in progress.
module spi_byte_shift_engine_unit #(
    parameter int unsigned BYTE_BITS = 8
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_we,
    input  logic [spibse_pkg::CFG_ADDR_W-1:0] cfg_addr,
    input  logic [spibse_pkg::CFG_DATA_W-1:0] cfg_wdata,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic [1:0]                        s_req_type,
    input  logic [7:0]                        s_tx_byte,
    input  logic                              s_edge_rising,
    input  logic                              s_data_in,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic                              m_data_out,
    output logic                              m_sck_level,
    output logic                              m_want_tick,
    output logic                              m_byte_done,
    output logic [7:0]                        m_rx_byte
);

    spibse_pkg::cfg_t    cfg_reg, cfg_next;
    spibse_pkg::item_t   item_reg;
    spibse_pkg::result_t result, result_reg;
    logic                in_valid_reg, in_valid_next;
    logic                out_valid_reg, out_valid_next;
    logic                out_free, step, abort;

    // The output register can take a new result when empty or being drained.
    assign out_free = !out_valid_reg || m_ready;
    assign step     = in_valid_reg && out_free;
    assign s_ready  = !in_valid_reg || out_free;

    // Configuration writes; only a real change of mode aborts the transfer.
    always_comb begin
        cfg_next = cfg_reg;
        abort    = 1'b0;
        if (cfg_we) begin
            case (cfg_addr)
                spibse_pkg::CFG_SPI_MODE: begin
                    cfg_next.spi_mode = cfg_wdata[1:0];
                    abort = (cfg_wdata[1:0] != cfg_reg.spi_mode);
                end
                spibse_pkg::CFG_LSB_FIRST:          cfg_next.lsb_first = cfg_wdata[0];
                spibse_pkg::CFG_LEAD_EDGE_FALLING:  cfg_next.lead_edge_falling = cfg_wdata[0];
                spibse_pkg::CFG_SAMPLE_ON_TRAILING: cfg_next.sample_on_trailing = cfg_wdata[0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        in_valid_next = in_valid_reg;
        if (s_valid && s_ready) begin
            in_valid_next = 1'b1;
        end else if (step) begin
            in_valid_next = 1'b0;
        end
        out_valid_next = out_valid_reg;
        if (step) begin
            out_valid_next = 1'b1;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg       <= '0;
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            cfg_reg       <= cfg_next;
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            item_reg.req_type    <= s_req_type;
            item_reg.tx_byte     <= s_tx_byte;
            item_reg.edge_rising <= s_edge_rising;
            item_reg.data_in     <= s_data_in;
        end
        if (step) begin
            result_reg <= result;
        end
    end

    spibse_core #(
        .BYTE_BITS(BYTE_BITS)
    ) u_core (
        .aclk   (aclk),
        .aresetn(aresetn),
        .cfg    (cfg_reg),
        .abort  (abort),
        .step   (step),
        .item   (item_reg),
        .result (result)
    );

    assign m_valid     = out_valid_reg;
    assign m_data_out  = result_reg.data_out;
    assign m_sck_level = result_reg.sck_level;
    assign m_want_tick = result_reg.want_tick;
    assign m_byte_done = result_reg.byte_done;
    assign m_rx_byte   = result_reg.rx_byte;

endmodule
